/* hw/rtl/vscd_pkg.sv */
// ----------------------------------------------------------------------------
// vscd_pkg
// shared types and constants of the voxel span column decoder
// ----------------------------------------------------------------------------
package vscd_pkg;

	// parse phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_COLOUR = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;

	// configuration register indexes
	localparam logic CFG_MAP_SIDE   = 1'b0;
	localparam logic CFG_MAP_HEIGHT = 1'b1;

	localparam int CFG_DATA_W = 10;
	localparam int SIDE_W     = 11;
	localparam int HGT_W      = 9;
	localparam int COUNT_W    = 25;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 25'h100_0000;

	localparam logic [9:0] MAP_SIDE_RST   = 10'd512;
	localparam logic [6:0] MAP_HEIGHT_RST = 7'd64;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [8:0]         column_x;
		logic [8:0]         column_y;
		logic [5:0]         height;
		logic [31:0]        color;
		logic [COUNT_W-1:0] block_total;
	} out_item_t;

endpackage

/* hw/rtl/vscd_in_stage.sv */
// ----------------------------------------------------------------------------
// vscd_in_stage
// input register in front of the parser
// ----------------------------------------------------------------------------
module vscd_in_stage import vscd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     consume,
	output logic     valid_s1,
	output in_item_t item_s1
);

	logic load;

	assign in_ready = !valid_s1 || consume;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_data;
		end
	end

endmodule

/* hw/rtl/vscd_parser.sv */
// ----------------------------------------------------------------------------
// vscd_parser
// span parser state and per-byte decode
// ----------------------------------------------------------------------------
module vscd_parser import vscd_pkg::*; #(
	parameter int CW = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  in_item_t          item,
	input  logic              out_free,
	input  logic [SIDE_W-1:0] side_used,
	input  logic [HGT_W-1:0]  height_used,
	output logic              consume,
	output logic              emit,
	output out_item_t         result
);

	logic [1:0]         phase_q, ph;
	logic [1:0]         bpos_q, bp;
	logic [7:0]         span_words_q, sw;
	logic [7:0]         top_start_q, ts;
	logic [7:0]         top_end_q, te;
	logic [7:0]         cidx_q, ci;
	logic [7:0]         skip_q, sk;
	logic [23:0]        cbytes_q, cb;
	logic [CW-1:0]      cur_x_q, cx;
	logic [CW-1:0]      cur_y_q, cy;
	logic               finished_q, fin;
	logic [COUNT_W-1:0] count_q, cnt;

	// span end: next column, skip of the bottom words, or the next header
	logic [8:0]    tops, rest;
	logic [CW:0]   x_inc, y_inc;
	logic          x_wrap, y_wrap;
	logic [1:0]    sd_phase;
	logic [7:0]    sd_skip;
	logic [CW-1:0] sd_x, sd_y;
	logic          sd_fin;
	logic [9:0]    cx_wide, cy_wide;

	assign tops   = (top_start_q <= top_end_q) ? (9'(top_end_q) - 9'(top_start_q) + 9'd1) : 9'd0;
	assign rest   = 9'(span_words_q) - 9'd1;
	assign x_inc  = (CW+1)'(cur_x_q) + (CW+1)'(1);
	assign y_inc  = (CW+1)'(cur_y_q) + (CW+1)'(1);
	assign x_wrap = SIDE_W'(x_inc) >= side_used;
	assign y_wrap = SIDE_W'(y_inc) >= side_used;

	always_comb begin
		sd_phase = PH_HEADER;
		sd_skip  = skip_q;
		sd_x     = cur_x_q;
		sd_y     = cur_y_q;
		sd_fin   = 1'b0;
		if (span_words_q == 8'd0) begin
			if (x_wrap) begin
				sd_x = '0;
				if (y_wrap) begin
					sd_y   = '0;
					sd_fin = 1'b1;
				end else begin
					sd_y = y_inc[CW-1:0];
				end
			end else begin
				sd_x = x_inc[CW-1:0];
			end
		end else if (rest > tops) begin
			sd_skip  = 8'(rest - tops);
			sd_phase = PH_SKIP;
		end
	end

	always_comb begin
		ph   = phase_q;
		bp   = bpos_q;
		sw   = span_words_q;
		ts   = top_start_q;
		te   = top_end_q;
		ci   = cidx_q;
		sk   = skip_q;
		cb   = cbytes_q;
		cx   = cur_x_q;
		cy   = cur_y_q;
		fin  = finished_q;
		cnt  = count_q;
		emit = 1'b0;
		if (item.frame_start) begin
			ph  = PH_HEADER;
			bp  = 2'd0;
			sw  = '0;
			ts  = '0;
			te  = '0;
			ci  = '0;
			sk  = '0;
			cb  = '0;
			cx  = '0;
			cy  = '0;
			fin = (side_used == '0);
		end
		if (!fin) begin
			case (ph)
				PH_HEADER: begin
					case (bp)
						2'd0:    sw = item.data_byte;
						2'd1:    ts = item.data_byte;
						2'd2:    te = item.data_byte;
						default: ;
					endcase
					if (bp == 2'd3) begin
						bp = 2'd0;
						if (top_start_q <= top_end_q) begin
							ci = top_start_q;
							cb = '0;
							ph = PH_COLOUR;
						end else begin
							ph  = sd_phase;
							sk  = sd_skip;
							cx  = sd_x;
							cy  = sd_y;
							fin = fin | sd_fin;
						end
					end else begin
						bp = bp + 2'd1;
					end
				end
				PH_COLOUR: begin
					case (bp)
						2'd0:    cb[7:0]   = cb[7:0] | item.data_byte;
						2'd1:    cb[15:8]  = cb[15:8] | item.data_byte;
						2'd2:    cb[23:16] = cb[23:16] | item.data_byte;
						default: ;
					endcase
					if (bp != 2'd3) begin
						bp = bp + 2'd1;
					end else begin
						bp = 2'd0;
						cb = '0;
						if (HGT_W'(cidx_q) < height_used) begin
							emit = 1'b1;
							if (count_q < COUNT_MAX) begin
								cnt = count_q + COUNT_W'(1);
							end
						end
						if (cidx_q >= top_end_q) begin
							ph  = sd_phase;
							sk  = sd_skip;
							cx  = sd_x;
							cy  = sd_y;
							fin = fin | sd_fin;
						end else begin
							ci = cidx_q + 8'd1;
						end
					end
				end
				default: begin
					if (bp != 2'd3) begin
						bp = bp + 2'd1;
					end else begin
						bp = 2'd0;
						if (sk != 8'd0) begin
							sk = sk - 8'd1;
						end
						if (sk == 8'd0) begin
							ph = PH_HEADER;
						end
					end
				end
			endcase
		end
		if (item.last_byte) begin
			fin = 1'b1;
		end
	end

	// a byte that writes a voxel waits until the result register is free
	assign consume = item_valid && (!emit || out_free);

	assign cx_wide = 10'(cur_x_q);
	assign cy_wide = 10'(cur_y_q);

	always_comb begin
		result.column_x    = cx_wide[8:0];
		result.column_y    = cy_wide[8:0];
		result.height      = cidx_q[5:0];
		result.color       = {item.data_byte, cbytes_q};
		result.block_total = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			bpos_q       <= 2'd0;
			span_words_q <= '0;
			top_start_q  <= '0;
			top_end_q    <= '0;
			cidx_q       <= '0;
			skip_q       <= '0;
			cbytes_q     <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			finished_q   <= 1'b1;
			count_q      <= '0;
		end else if (consume) begin
			phase_q      <= ph;
			bpos_q       <= bp;
			span_words_q <= sw;
			top_start_q  <= ts;
			top_end_q    <= te;
			cidx_q       <= ci;
			skip_q       <= sk;
			cbytes_q     <= cb;
			cur_x_q      <= cx;
			cur_y_q      <= cy;
			finished_q   <= fin;
			count_q      <= cnt;
		end
	end

	// each delivered write raises the count by one until it saturates
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && consume) |=>
		(count_q == COUNT_MAX || count_q == $past(count_q) + COUNT_W'(1)))
		else $error("block count did not step on a voxel write");

	// colour words run from top start up to top end
	a_colour_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COLOUR) |-> (cidx_q <= top_end_q))
		else $error("colour index past top end");

	// skip phase always has words left
	a_skip_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_q != 8'd0))
		else $error("skip phase with nothing to skip");

endmodule

/* hw/rtl/vscd_out_stage.sv */
// ----------------------------------------------------------------------------
// vscd_out_stage
// result register toward the receiver
// ----------------------------------------------------------------------------
module vscd_out_stage import vscd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t result,
	output logic      out_free,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      valid_q;
	out_item_t data_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

/* hw/rtl/voxel_span_column_decoder_unit.sv */
// ----------------------------------------------------------------------------
// voxel_span_column_decoder_unit
// byte-stream span decoder that turns a column map into voxel writes
// ----------------------------------------------------------------------------
// in channel: one map byte per request, with frame_start marking the first
// byte of a file and last_byte the final one; out channel: one request per
// voxel write (column, height, color, running block count).
// cfg channel: index 0 map_side, index 1 map_height; always ready. It is to be
// written by the user only while the decoder is idle; not enforced by the block.
// throughput: one byte per cycle while no voxel write waits for the result
// register; the parser state is a handful of small counters updated by one
// short decode between the input register and the result register.
// path: input register, one decode, then the result register holds the write.
// stall: while the result register holds an untaken write, bytes that write
// nothing still flow; a byte that would write waits in the input register,
// and in_ready drops once that register is full and cannot move.
// reset: parser idles until a byte with frame_start, block count cleared,
// map_side 512 and map_height 64; no clearing pass.
// ----------------------------------------------------------------------------
module voxel_span_column_decoder_unit import vscd_pkg::*; #(
	parameter int MAX_SIDE   = 512,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// coordinate counter width, at least one bit
	localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	logic [9:0]        map_side_q;
	logic [6:0]        map_height_q;
	logic [SIDE_W-1:0] side_used;
	logic [HGT_W-1:0]  height_used;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      consume;
	logic      emit;
	logic      out_free;
	out_item_t result;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_side_q   <= MAP_SIDE_RST;
			map_height_q <= MAP_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAP_SIDE:   map_side_q   <= cfg_data;
				CFG_MAP_HEIGHT: map_height_q <= cfg_data[6:0];
				default:        ;
			endcase
		end
	end

	// clamp the registers to what the counters were built for
	assign side_used = (SIDE_W'(map_side_q) < SIDE_W'(MAX_SIDE)) ?
		SIDE_W'(map_side_q) : SIDE_W'(MAX_SIDE);
	assign height_used = (HGT_W'(map_height_q) < HGT_W'(MAX_HEIGHT)) ?
		HGT_W'(map_height_q) : HGT_W'(MAX_HEIGHT);

	// input register
	vscd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.consume  (consume),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// parser: one decode step per byte
	vscd_parser #(
		.CW (CW)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (valid_s1),
		.item        (item_s1),
		.out_free    (out_free),
		.side_used   (side_used),
		.height_used (height_used),
		.consume     (consume),
		.emit        (emit),
		.result      (result)
	);

	// result register
	vscd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit && consume),
		.result    (result),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a writing byte behind a stalled result must hold the input side
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && valid_s1 && emit) |-> !in_ready)
		else $error("input taken while a write is blocked");

endmodule

/* tb/sv/tb_voxel_span_column_decoder_unit.sv */
// ----------------------------------------------------------------------------
// tb_voxel_span_column_decoder_unit
// self-checking testbench of the voxel span column decoder
// ----------------------------------------------------------------------------
// map bytes are queued by the stimulus process and presented one request at a
// time by a clocked driver. Each accepted byte runs through an in-bench span
// parser that predicts the voxel write, if any. A clocked monitor checks each
// accepted write field by field against the oldest prediction. Both sides idle
// at random, with one calm stretch. Map side and height are changed between
// phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_voxel_span_column_decoder_unit;
	import vscd_pkg::*;

	localparam int SIDE_CAP     = 512;
	localparam int HEIGHT_CAP   = 64;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_GAP    = 4;
	localparam int RANDOM_BYTES = 500;
	localparam int IDLE_PCT     = 27;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = CFG_MAP_SIDE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	voxel_span_column_decoder_unit #(
		.MAX_SIDE   (SIDE_CAP),
		.MAX_HEIGHT (HEIGHT_CAP)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// bytes waiting for the driver, and voxel writes waiting for the dut
	in_item_t  map_bytes[$];
	out_item_t pending_voxels[$];
	// scratch buffer for one map file under construction
	logic [7:0] frame_buf[$];

	int  err_count   = 0;
	int  cycle_count = 0;
	int  sent_count  = 0;
	int  random_sent = 0;
	logic in_fire    = 1'b0;
	// both sides stop idling for a stretch of requests
	wire calm = (sent_count >= 150) && (sent_count < 320);

	// ------------------------------------------------------------------------
	// span parser mirror: configuration and parse state
	// ------------------------------------------------------------------------
	logic [9:0]         side_reg;
	logic [6:0]         height_reg;
	logic [1:0]         phase;
	logic [1:0]         bpos;
	logic [7:0]         n_words;
	logic [7:0]         s_top;
	logic [7:0]         e_top;
	logic [7:0]         cidx;
	logic [7:0]         skip_cnt;
	logic [23:0]        cbytes;
	logic [8:0]         px;
	logic [8:0]         py;
	logic               idle;
	logic [COUNT_W-1:0] blocks;

	// clock and the one reset at the start
	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic logic [9:0] side_in_use();
		return (side_reg < 10'(SIDE_CAP)) ? side_reg : 10'(SIDE_CAP);
	endfunction

	// end of a span: either the column ends, a skip of bottom words starts,
	// or the next header follows directly
	function automatic void close_span();
		logic [8:0] tops;
		logic [8:0] rest;
		logic [9:0] nx;
		if (n_words == 8'd0) begin
			phase = PH_HEADER;
			nx = {1'b0, px} + 10'd1;
			if (nx >= side_in_use()) begin
				px = '0;
				nx = {1'b0, py} + 10'd1;
				if (nx >= side_in_use()) begin
					// map complete
					py = '0;
					idle = 1'b1;
				end else begin
					py = nx[8:0];
				end
			end else begin
				px = nx[8:0];
			end
		end else begin
			tops = (s_top <= e_top) ? ({1'b0, e_top} - {1'b0, s_top} + 9'd1) : 9'd0;
			rest = {1'b0, n_words} - 9'd1;
			if (rest > tops) begin
				skip_cnt = 8'(rest - tops);
				phase = PH_SKIP;
			end else begin
				// short span, nothing to skip
				phase = PH_HEADER;
			end
		end
	endfunction

	// one map byte in, at most one voxel write out
	function automatic bit decode_byte(input in_item_t it, output out_item_t w);
		bit         hit;
		logic [7:0] hmax;
		hit = 1'b0;
		w = '0;
		hmax = (height_reg < 7'(HEIGHT_CAP)) ? {1'b0, height_reg} : 8'(HEIGHT_CAP);
		if (it.frame_start) begin
			phase = PH_HEADER;
			bpos = '0;
			n_words = '0;
			s_top = '0;
			e_top = '0;
			cidx = '0;
			skip_cnt = '0;
			cbytes = '0;
			px = '0;
			py = '0;
			idle = (side_in_use() == 10'd0);
		end
		if (!idle) begin
			case (phase)
				PH_HEADER: begin
					case (bpos)
						2'd0: n_words = it.data_byte;
						2'd1: s_top = it.data_byte;
						2'd2: e_top = it.data_byte;
						default: ;
					endcase
					if (bpos == 2'd3) begin
						bpos = '0;
						if (s_top <= e_top) begin
							cidx = s_top;
							cbytes = '0;
							phase = PH_COLOUR;
						end else begin
							// empty top run
							close_span();
						end
					end else begin
						bpos = bpos + 2'd1;
					end
				end
				PH_COLOUR: begin
					if (bpos != 2'd3) begin
						cbytes = cbytes | (24'(it.data_byte) << (8 * bpos));
						bpos = bpos + 2'd1;
					end else begin
						if (cidx < hmax) begin
							if (blocks < COUNT_MAX)
								blocks = blocks + 1'b1;
							w.column_x = px;
							w.column_y = py;
							w.height = cidx[5:0];
							w.color = {it.data_byte, cbytes};
							w.block_total = blocks;
							hit = 1'b1;
						end
						bpos = '0;
						cbytes = '0;
						if (cidx >= e_top)
							close_span();
						else
							cidx = cidx + 8'd1;
					end
				end
				PH_SKIP: begin
					if (bpos != 2'd3) begin
						bpos = bpos + 2'd1;
					end else begin
						bpos = '0;
						if (skip_cnt != 8'd0)
							skip_cnt = skip_cnt - 8'd1;
						if (skip_cnt == 8'd0)
							phase = PH_HEADER;
					end
				end
				default: ;
			endcase
			if (it.last_byte)
				idle = 1'b1;
		end
		return hit;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0d] mismatch: %s", cycle_count, what);
		err_count++;
	endtask

	// ------------------------------------------------------------------------
	// driver: new request or idle on the falling edge, once the previous one
	// was taken; out_ready stalls at random
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (map_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				in_data <= map_bytes.pop_front();
				in_valid <= 1'b1;
				sent_count++;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// ------------------------------------------------------------------------
	// monitor: everything is sampled on the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		out_item_t want;
		out_item_t got;
		cycle_count++;
		in_fire <= in_valid && in_ready;
		if (!arst_n) begin
			// mirror of the reset state: idle until a frame start
			side_reg = MAP_SIDE_RST;
			height_reg = MAP_HEIGHT_RST;
			phase = PH_HEADER;
			bpos = '0;
			n_words = '0;
			s_top = '0;
			e_top = '0;
			cidx = '0;
			skip_cnt = '0;
			cbytes = '0;
			px = '0;
			py = '0;
			idle = 1'b1;
			blocks = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MAP_SIDE)
					side_reg = cfg_data;
				else
					height_reg = cfg_data[6:0];
			end
			if (in_valid && in_ready) begin
				if (decode_byte(in_data, want))
					pending_voxels.push_back(want);
			end
			if (out_valid && out_ready) begin
				got = out_data;
				if (pending_voxels.size() == 0) begin
					report_mismatch($sformatf("unexpected write x=%0d y=%0d z=%0d color=%h",
						got.column_x, got.column_y, got.height, got.color));
				end else begin
					want = pending_voxels.pop_front();
					if (got.column_x !== want.column_x)
						report_mismatch($sformatf("column_x %0d, expected %0d",
							got.column_x, want.column_x));
					if (got.column_y !== want.column_y)
						report_mismatch($sformatf("column_y %0d, expected %0d",
							got.column_y, want.column_y));
					if (got.height !== want.height)
						report_mismatch($sformatf("height %0d, expected %0d",
							got.height, want.height));
					if (got.color !== want.color)
						report_mismatch($sformatf("color %h, expected %h",
							got.color, want.color));
					if (got.block_total !== want.block_total)
						report_mismatch($sformatf("block_total %0d, expected %0d",
							got.block_total, want.block_total));
				end
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d writes still expected",
			cycle_count, pending_voxels.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b, input bit fs, input bit lb);
		in_item_t it;
		it.data_byte = b;
		it.frame_start = fs;
		it.last_byte = lb;
		map_bytes.push_back(it);
	endtask

	// wait until every request is taken and every write has come out, then
	// give the input register time to empty before any register write
	task automatic drain();
		do @(posedge clk); while (map_bytes.size() != 0 || in_valid);
		do @(negedge clk); while (pending_voxels.size() != 0);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	// both registers back to back, valid held high across the two requests
	task automatic set_map(input logic [9:0] side_val, input logic [9:0] height_word);
		@(negedge clk);
		cfg_index <= CFG_MAP_SIDE;
		cfg_data <= side_val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= CFG_MAP_HEIGHT;
		cfg_data <= height_word;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_word();
		logic [31:0] r;
		int          sel;
		r = $urandom;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			r = '0;
		else if (sel == 1)
			r = '1;
		for (int i = 0; i < 4; i++)
			frame_buf.push_back(r[8*i +: 8]);
	endtask

	// one well-formed column: a few continuing spans and a closing one
	task automatic add_column();
		int         spans;
		int         tops;
		int         sel;
		int         skips;
		logic [7:0] s;
		logic [7:0] e;
		logic [7:0] nw;
		spans = $urandom_range(0, 2);
		for (int k = 0; k <= spans; k++) begin
			tops = $urandom_range(0, 3);
			sel = $urandom_range(0, 99);
			if (tops == 0) begin
				s = 8'($urandom_range(1, 255));
				e = 8'($urandom_range(0, s - 1));
			end else begin
				if (sel < 70)
					s = 8'($urandom_range(0, 63));
				else if (sel < 90)
					s = 8'($urandom_range(60, 70));
				else
					s = 8'($urandom_range(250, 256 - tops));
				e = 8'(int'(s) + tops - 1);
			end
			sel = $urandom_range(0, 99);
			if (k == spans)
				nw = 8'd0;
			else if (sel < 65)
				nw = 8'(1 + tops + $urandom_range(0, 2));
			else
				nw = 8'($urandom_range(1, tops + 1));
			frame_buf.push_back(nw);
			frame_buf.push_back(s);
			frame_buf.push_back(e);
			frame_buf.push_back(8'($urandom));
			for (int i = 0; i < tops; i++)
				add_word();
			// bottom colours, skipped by the parser
			skips = (nw > 0 && int'(nw) - 1 > tops) ? int'(nw) - 1 - tops : 0;
			for (int i = 0; i < skips; i++)
				add_word();
		end
	endtask

	// one map file for the current side, or a burst of noise
	task automatic send_frame(input logic [9:0] side_val);
		int          kind;
		int          cols;
		int          len;
		int          side_eff;
		bit          partial;
		bit          lb;
		logic [31:0] r;
		kind = $urandom_range(0, 99);
		side_eff = (side_val < SIDE_CAP) ? int'(side_val) : SIDE_CAP;
		if (kind < 15) begin
			// noise: random bytes, stray frame starts and ends
			len = $urandom_range(4, 20);
			for (int i = 0; i < len; i++) begin
				r = $urandom;
				push_byte(r[7:0], i == 0 || r[14:10] == 0, r[20:16] == 0);
			end
			random_sent += len;
		end else begin
			frame_buf.delete();
			cols = side_eff * side_eff;
			partial = (cols == 0 || cols > 9);
			if (partial)
				cols = $urandom_range(1, 6);
			for (int c = 0; c < cols; c++)
				add_column();
			len = frame_buf.size();
			// truncated file: cut anywhere, inside a header or a word
			if (kind < 30 && len > 1) begin
				len = $urandom_range(1, len - 1);
				partial = 1'b1;
			end
			lb = partial || ($urandom_range(0, 1) == 1);
			for (int i = 0; i < len; i++)
				push_byte(frame_buf[i], i == 0, lb && i == len - 1);
			random_sent += len;
			// a few bytes past the end, all ignored
			if (!partial && $urandom_range(0, 3) == 0)
				for (int i = 0; i < 3; i++)
					push_byte(8'($urandom), 1'b0, 1'b0);
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int          sel;
		logic [9:0]  side;
		logic [6:0]  hgt;
		logic [31:0] r;
		wait (arst_n);

		// reset settings: side 512, height 64
		push_byte(8'hAA, 1'b0, 1'b0);                    // idle after reset, ignored
		push_byte(8'd2, 1'b1, 1'b0);                     // N=2 S=63 E=63, short span
		push_byte(8'd63, 1'b0, 1'b0);
		push_byte(8'd63, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);                    // color ff00ff00 at top height
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'd0, 1'b0, 1'b0);                     // N=0 S=E=64, write dropped
		push_byte(8'd64, 1'b0, 1'b0);
		push_byte(8'd64, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h11, 1'b0, 1'b0);
		push_byte(8'h22, 1'b0, 1'b0);
		push_byte(8'h33, 1'b0, 1'b0);
		push_byte(8'h44, 1'b0, 1'b0);
		push_byte(8'd0, 1'b0, 1'b0);                     // empty top run, then end of file
		push_byte(8'd3, 1'b0, 1'b0);
		push_byte(8'd0, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte(8'h55, 1'b0, 1'b0);                    // after last byte, ignored
		drain();

		// one-column map completes on its first span; height above the cap
		set_map(10'd1, 10'h3FF);
		push_byte(8'd0, 1'b1, 1'b0);
		push_byte(8'd1, 1'b0, 1'b0);
		push_byte(8'd0, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);                    // map complete, ignored
		drain();

		// side 0 idles at once, height 0 drops everything
		set_map(10'd0, 10'd0);
		push_byte(8'd0, 1'b1, 1'b0);
		drain();

		// random phases: new settings, then one or two files or bursts of noise
		while (random_sent < RANDOM_BYTES) begin
			sel = $urandom_range(0, 99);
			if (sel < 60)
				side = 10'($urandom_range(1, 3));
			else if (sel < 68)
				side = 10'd0;
			else if (sel < 78)
				side = 10'($urandom_range(4, 40));
			else if (sel < 89)
				side = 10'd512;
			else
				side = 10'($urandom_range(513, 1023));
			sel = $urandom_range(0, 99);
			if (sel < 8)
				hgt = 7'd0;
			else if (sel < 18)
				hgt = 7'd1;
			else if (sel < 35)
				hgt = 7'd64;
			else if (sel < 50)
				hgt = 7'($urandom_range(65, 127));
			else
				hgt = 7'($urandom_range(2, 63));
			r = $urandom;
			set_map(side, {r[2:0], hgt});
			repeat ($urandom_range(1, 2))
				send_frame(side);
			drain();
		end

		drain();
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/vscd_pkg.sv
hw/rtl/vscd_in_stage.sv
hw/rtl/vscd_parser.sv
hw/rtl/vscd_out_stage.sv
hw/rtl/voxel_span_column_decoder_unit.sv
tb/sv/tb_voxel_span_column_decoder_unit.sv
